### rtl/core/srec_pkg.sv
// Shared types and constants for the S3 record loader.
`default_nettype none
package srec_pkg;

	localparam logic [24:0] IMAGE_BYTES = 25'd16777216;

	localparam logic [7:0] CH_S   = 8'h53;
	localparam logic [7:0] CH_3   = 8'h33;
	localparam logic [7:0] CH_NL  = 8'h0a;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UF  = 8'h46;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LF  = 8'h66;

	localparam logic [7:0] COUNT_MIN = 8'd5;
	localparam logic [7:0] SUM_GOOD  = 8'hff;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_OK    = 2'd1;
	localparam logic [1:0] KIND_FATAL = 2'd2;

	localparam logic [2:0] ERR_NONE   = 3'd0;
	localparam logic [2:0] ERR_NOT_S  = 3'd1;
	localparam logic [2:0] ERR_SUM    = 3'd2;
	localparam logic [2:0] ERR_RANGE  = 3'd3;
	localparam logic [2:0] ERR_HEX    = 3'd4;
	localparam logic [2:0] ERR_COUNT  = 3'd5;

	localparam int EVQ_DEPTH = 2;
	localparam int OUTQ_DEPTH = 2;

	typedef enum logic [2:0] {
		ROLE_COUNT,
		ROLE_ADDR,
		ROLE_ADDR_LAST,
		ROLE_DATA,
		ROLE_CHECK,
		ROLE_FATAL
	} role_t;

	typedef struct packed {
		role_t       role;
		logic [7:0]  value;
		logic [2:0]  code;
	} event_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [23:0] byte_address;
		logic [7:0]  byte_value;
		logic [2:0]  error_code;
	} result_t;

endpackage
`default_nettype wire

### rtl/core/srec_fifo.sv
// Small register queue used between the loader stages and at the result side.
`default_nettype none
module srec_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_COUNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

### rtl/core/srec_front.sv
// Character front end: line framing, hex pairing and byte role tagging.
`default_nettype none
module srec_front
	import srec_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] character,
	output logic            ev_push,
	output event_t          ev_data
);

	localparam logic [2:0] PH_LINE = 3'd0;
	localparam logic [2:0] PH_TYPE = 3'd1;
	localparam logic [2:0] PH_SKIP = 3'd2;
	localparam logic [2:0] PH_REC  = 3'd3;
	localparam logic [2:0] PH_TAIL = 3'd4;
	localparam logic [2:0] PH_DEAD = 3'd5;

	function automatic logic [4:0] hex_decode(input logic [7:0] ch);
		logic [7:0] d;
		d = 8'h00;
		case (ch) inside
			[CH_0:CH_9]: begin
				d = ch - CH_0;
				return {1'b1, d[3:0]};
			end
			[CH_UA:CH_UF]: begin
				d = ch - CH_UA + 8'd10;
				return {1'b1, d[3:0]};
			end
			[CH_LA:CH_LF]: begin
				d = ch - CH_LA + 8'd10;
				return {1'b1, d[3:0]};
			end
			default: return 5'b0_0000;
		endcase
	endfunction

	logic [2:0] phase_q;
	logic       pend_q;
	logic [3:0] high_q;
	logic [7:0] count_q;
	logic [7:0] seen_q;

	logic [2:0] phase_d;
	logic       pend_d;
	logic [3:0] high_d;
	logic [7:0] count_d;
	logic [7:0] seen_d;
	logic [4:0] hex;
	logic [7:0] byte_v;

	assign hex    = hex_decode(character);
	assign byte_v = {high_q, hex[3:0]};

	always_comb begin
		phase_d       = phase_q;
		pend_d        = pend_q;
		high_d        = high_q;
		count_d       = count_q;
		seen_d        = seen_q;
		ev_push       = 1'b0;
		ev_data.role  = ROLE_FATAL;
		ev_data.value = byte_v;
		ev_data.code  = ERR_NONE;
		if (accept) begin
			case (phase_q)
				PH_LINE: begin
					if (character != CH_S) begin
						ev_push      = 1'b1;
						ev_data.code = ERR_NOT_S;
						phase_d      = PH_DEAD;
					end else begin
						phase_d = PH_TYPE;
					end
				end
				PH_TYPE: begin
					if (character == CH_3) begin
						phase_d = PH_REC;
						pend_d  = 1'b0;
						seen_d  = '0;
					end else if (character == CH_NL) begin
						phase_d = PH_LINE;
					end else begin
						phase_d = PH_SKIP;
					end
				end
				PH_REC: begin
					if (!hex[4]) begin
						ev_push      = 1'b1;
						ev_data.code = ERR_HEX;
						phase_d      = PH_DEAD;
					end else if (!pend_q) begin
						high_d = hex[3:0];
						pend_d = 1'b1;
					end else begin
						pend_d  = 1'b0;
						seen_d  = seen_q + 1'b1;
						ev_push = 1'b1;
						if (seen_q == 8'd0) begin
							count_d = byte_v;
							if (byte_v < COUNT_MIN) begin
								ev_data.code = ERR_COUNT;
								phase_d      = PH_DEAD;
							end else begin
								ev_data.role = ROLE_COUNT;
							end
						end else if (seen_q < 8'd4) begin
							ev_data.role = ROLE_ADDR;
						end else if (seen_q == 8'd4) begin
							ev_data.role = ROLE_ADDR_LAST;
						end else if (seen_q < count_q) begin
							ev_data.role = ROLE_DATA;
						end else begin
							ev_data.role = ROLE_CHECK;
							phase_d      = PH_TAIL;
						end
					end
				end
				PH_SKIP, PH_TAIL: begin
					if (character == CH_NL) begin
						phase_d = PH_LINE;
					end
				end
				PH_DEAD: begin
					phase_d = PH_DEAD;
				end
				default: begin
					phase_d = PH_LINE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LINE;
			pend_q  <= 1'b0;
			high_q  <= '0;
			count_q <= '0;
			seen_q  <= '0;
		end else begin
			phase_q <= phase_d;
			pend_q  <= pend_d;
			high_q  <= high_d;
			count_q <= count_d;
			seen_q  <= seen_d;
		end
	end

endmodule
`default_nettype wire

### rtl/core/srec_back.sv
// Record back end: checksum, address offset, range check and result build.
`default_nettype none
module srec_back
	import srec_pkg::*;
#(
	parameter logic [24:0] IMAGE_SIZE = IMAGE_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [31:0] wr_data,
	input  wire logic        ev_empty,
	input  wire event_t      ev_data,
	output logic             ev_pop,
	input  wire logic        out_full,
	output logic             out_push,
	output result_t          out_data
);

	logic [31:0] base_q;
	logic        fatal_q;
	logic [7:0]  sum_q;
	logic [23:0] addr_q;
	logic [24:0] limit_q;
	logic [23:0] wp_q;
	logic        range_q;

	logic        res_valid;
	logic [7:0]  sum_next;
	logic [31:0] image_addr;

	assign ev_pop     = !ev_empty && !out_full;
	assign out_push   = ev_pop && res_valid && !fatal_q;
	assign sum_next   = sum_q + ev_data.value;
	assign image_addr = {addr_q, ev_data.value} + base_q;

	always_comb begin
		res_valid             = 1'b0;
		out_data.kind         = KIND_DATA;
		out_data.byte_address = '0;
		out_data.byte_value   = '0;
		out_data.error_code   = ERR_NONE;
		case (ev_data.role)
			ROLE_DATA: begin
				res_valid             = range_q;
				out_data.byte_address = wp_q;
				out_data.byte_value   = ev_data.value;
			end
			ROLE_CHECK: begin
				res_valid = 1'b1;
				if (sum_next != SUM_GOOD) begin
					out_data.kind       = KIND_FATAL;
					out_data.error_code = ERR_SUM;
				end else if (!range_q) begin
					out_data.kind       = KIND_FATAL;
					out_data.error_code = ERR_RANGE;
				end else begin
					out_data.kind = KIND_OK;
				end
			end
			ROLE_FATAL: begin
				res_valid           = 1'b1;
				out_data.kind       = KIND_FATAL;
				out_data.error_code = ev_data.code;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			fatal_q <= 1'b0;
			sum_q   <= '0;
			addr_q  <= '0;
			limit_q <= '0;
			wp_q    <= '0;
			range_q <= 1'b0;
		end else begin
			if (wr_en) begin
				base_q <= wr_data;
			end
			if (ev_pop && !fatal_q) begin
				case (ev_data.role)
					ROLE_COUNT: begin
						sum_q   <= ev_data.value;
						addr_q  <= '0;
						range_q <= 1'b0;
						limit_q <= IMAGE_SIZE - 25'(ev_data.value - COUNT_MIN);
					end
					ROLE_ADDR: begin
						sum_q  <= sum_next;
						addr_q <= {addr_q[15:0], ev_data.value};
					end
					ROLE_ADDR_LAST: begin
						sum_q   <= sum_next;
						wp_q    <= image_addr[23:0];
						range_q <= (image_addr <= {7'd0, limit_q});
					end
					ROLE_DATA: begin
						sum_q <= sum_next;
						if (range_q) begin
							wp_q <= wp_q + 1'b1;
						end
					end
					ROLE_CHECK: begin
						sum_q <= sum_next;
						if (sum_next != SUM_GOOD || !range_q) begin
							fatal_q <= 1'b1;
						end
					end
					ROLE_FATAL: begin
						fatal_q <= 1'b1;
					end
					default: begin
						fatal_q <= fatal_q;
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/srec_s3_record_loader_unit.sv
// Top level of the S3 record loader: front end, event queue, back end, result queue.
//
//   channel   direction  handshake       payload
//   input     in         push / full     character
//   result    out        pop / empty     kind, byte_address, byte_value, error_code
//   config    in         wr_en           wr_data (base offset)
//
// One character per cycle is taken while full is low; a result reaches the ports
// through the event queue and then the result queue, both of them registered.
// Reset is asynchronous and needs no clearing pass; the block is ready at once.
// full rises only when the two-entry event queue fills, which happens when
// the result queue is held full by a consumer that does not pop.
`default_nettype none
module srec_s3_record_loader_unit
	import srec_pkg::*;
#(
	parameter logic [24:0] IMAGE_SIZE = IMAGE_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  character,
	input  wire logic        pop,
	output logic             empty,
	output logic [1:0]       kind,
	output logic [23:0]      byte_address,
	output logic [7:0]       byte_value,
	output logic [2:0]       error_code,
	input  wire logic        wr_en,
	input  wire logic [31:0] wr_data
);

	logic    accept;
	logic    ev_push;
	event_t  ev_in;
	event_t  ev_out;
	logic    ev_empty;
	logic    ev_pop;
	logic    out_full;
	logic    out_push;
	result_t res_in;
	result_t res_out;

	assign accept       = push && !full;
	assign kind         = res_out.kind;
	assign byte_address = res_out.byte_address;
	assign byte_value   = res_out.byte_value;
	assign error_code   = res_out.error_code;

	srec_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.character (character),
		.ev_push   (ev_push),
		.ev_data   (ev_in)
	);

	srec_fifo #(
		.WIDTH ($bits(event_t)),
		.DEPTH (EVQ_DEPTH)
	) u_evq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (ev_push),
		.wdata  (ev_in),
		.full   (full),
		.pop    (ev_pop),
		.rdata  (ev_out),
		.empty  (ev_empty)
	);

	srec_back #(
		.IMAGE_SIZE (IMAGE_SIZE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_data  (wr_data),
		.ev_empty (ev_empty),
		.ev_data  (ev_out),
		.ev_pop   (ev_pop),
		.out_full (out_full),
		.out_push (out_push),
		.out_data (res_in)
	);

	srec_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUTQ_DEPTH)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (res_in),
		.full   (out_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

endmodule
`default_nettype wire
